>>> design/dsc_pkg.sv
// Shared constants, types and per-channel arithmetic for the 2x2 box-average downscaler.
// Used by every module under design/ except dsc_ram; depends on nothing.
package dsc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int DIM_W      = 13;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int SUM_W      = CH_W + 1;
    localparam int PAIR_W     = SUM_W * NUM_CH;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [PAIR_W-1:0] pair_t;

    typedef struct packed {
        logic             wr;
        logic             rd;
        logic             last;
        logic [IDX_W-1:0] idx;
    } line_op_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic pair_t pair_add(input pixel_t a, input pixel_t b);
        pair_t s;
        s = '0;
        for (int c = 0; c < NUM_CH; c++)
            s[c*SUM_W +: SUM_W] = SUM_W'(a[c*CH_W +: CH_W]) + SUM_W'(b[c*CH_W +: CH_W]);
        return s;
    endfunction

    function automatic pixel_t block_mean(input pair_t top, input pair_t bot);
        pixel_t          p;
        logic [SUM_W:0]  s;
        p = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            s = (SUM_W+1)'(top[c*SUM_W +: SUM_W]) + (SUM_W+1)'(bot[c*SUM_W +: SUM_W]);
            p[c*CH_W +: CH_W] = s[SUM_W:2];
        end
        return p;
    endfunction

endpackage

>>> design/dsc_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem_reg[addr] <= wdata;
            else
                rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/dsc_ctrl.sv
// Frame position counters, dimension registers, held pixel and line-store request decode.
// Depends on dsc_pkg.
module dsc_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsc_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             accept,
    input  dsc_pkg::pixel_t                  pixel,
    output dsc_pkg::line_op_t                op,
    output dsc_pkg::pair_t                   pair
);

    logic [dsc_pkg::DIM_W-1:0] width_reg, width_next;
    logic [dsc_pkg::DIM_W-1:0] height_reg, height_next;
    logic [dsc_pkg::COL_W-1:0] col_reg, col_next;
    logic [dsc_pkg::ROW_W-1:0] row_reg, row_next;
    dsc_pkg::pixel_t           held_reg, held_next;

    logic [dsc_pkg::DIM_W-1:0] w, h, w_even, h_even;
    logic [dsc_pkg::DIM_W-1:0] x_ext, y_ext, x_inc, y_inc;
    logic                      in_block;

    assign w      = dsc_pkg::clamp_dim(width_reg, dsc_pkg::WIDTH_LIMIT);
    assign h      = dsc_pkg::clamp_dim(height_reg, dsc_pkg::HEIGHT_LIMIT);
    assign w_even = {w[dsc_pkg::DIM_W-1:1], 1'b0};
    assign h_even = {h[dsc_pkg::DIM_W-1:1], 1'b0};
    assign x_ext  = dsc_pkg::DIM_W'(col_reg);
    assign y_ext  = dsc_pkg::DIM_W'(row_reg);
    assign x_inc  = x_ext + dsc_pkg::DIM_W'(1);
    assign y_inc  = y_ext + dsc_pkg::DIM_W'(1);

    assign in_block = col_reg[0] && (x_ext < w_even) && (y_ext < h_even);

    always_comb
    begin
        op.wr   = in_block && !row_reg[0];
        op.rd   = in_block && row_reg[0];
        op.last = in_block && row_reg[0]
                  && (x_ext == w_even - dsc_pkg::DIM_W'(1))
                  && (y_ext == h_even - dsc_pkg::DIM_W'(1));
        op.idx  = col_reg[dsc_pkg::COL_W-1:1];
    end

    assign pair = dsc_pkg::pair_add(held_reg, pixel);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        held_next   = held_reg;
        if (cfg_we)
        begin
            unique case (dsc_pkg::cfg_reg_t'(cfg_index))
                dsc_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                dsc_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (!col_reg[0])
                held_next = pixel;
            if (x_inc >= w)
            begin
                col_next = '0;
                if (y_inc >= h)
                    row_next = '0;
                else
                    row_next = y_inc[dsc_pkg::ROW_W-1:0];
            end
            else
                col_next = x_inc[dsc_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dsc_pkg::WIDTH_RESET;
            height_reg <= dsc_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            held_reg   <= held_next;
        end
    end

endmodule

>>> design/dsc_out.sv
// Averaging stage and output register with back-pressure handling.
// Depends on dsc_pkg; takes line-store read data from dsc_ram.
module dsc_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  dsc_pkg::pair_t  pair,
    input  logic            last,
    input  dsc_pkg::pair_t  top_pair,
    output logic            take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output dsc_pkg::pixel_t m_tdata,
    output logic            m_tlast
);

    logic            s1_valid_reg, s1_valid_next;
    dsc_pkg::pair_t  s1_pair_reg, s1_pair_next;
    logic            s1_last_reg, s1_last_next;
    logic            m_valid_reg, m_valid_next;
    dsc_pkg::pixel_t m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            advance;

    assign advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign take    = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_pair_next  = s1_pair_reg;
        s1_last_next  = s1_last_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
            s1_pair_next  = pair;
            s1_last_next  = last;
        end
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
            m_data_next  = dsc_pkg::block_mean(top_pair, s1_pair_reg);
            m_last_next  = s1_last_reg;
        end
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pair_reg <= s1_pair_next;
        s1_last_reg <= s1_last_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> design/image_downscale_2x2_box_average_core.sv
// 2x2 box-average downscaler, top level: 24-bit BGR pixel stream in, half-size stream out.
// Depends on dsc_pkg, dsc_ctrl, dsc_ram and dsc_out.
// Results pass the averaging stage register, then the output register that drives m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; one single-port line-store access each.
// Reset: position counters and held pixel clear, size returns to 640x480; line store is kept.
module image_downscale_2x2_box_average_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsc_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // blue_in, green_in, red_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // blue_out, green_out, red_out
    output logic                          m_tlast
);

    logic              s_accept;
    dsc_pkg::line_op_t op;
    dsc_pkg::pair_t    pair;
    dsc_pkg::pair_t    top_pair;
    logic              take;

    assign s_tready = take;
    assign s_accept = s_tvalid && take;

    dsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (s_accept),
        .pixel     (s_tdata),
        .op        (op),
        .pair      (pair)
    );

    dsc_ram #(
        .WIDTH (dsc_pkg::PAIR_W),
        .DEPTH (dsc_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .en    (s_accept && (op.wr || op.rd)),
        .we    (op.wr),
        .addr  (op.idx),
        .wdata (pair),
        .rdata (top_pair)
    );

    dsc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s_accept && op.rd),
        .pair     (pair),
        .last     (op.last),
        .top_pair (top_pair),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.wr && op.rd))
        else $error("line store read and write requested together");

    a_cfg_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !op.rd && !op.wr)
        else $error("frame position not restarted after register write");

    a_last_is_emit: assert property (@(posedge clk) disable iff (!rst_n)
        op.last |-> op.rd)
        else $error("frame end flagged on a pixel that emits no result");
`endif

endmodule

>>> tb/sv/tb_image_downscale_2x2_box_average_core.sv
// Self-checking testbench for the 2x2 box-average downscaler core.
// Drives BGR pixel requests with random gaps and back-pressure, predicts each averaged
// output pixel and frame-end flag, and checks every result; depends on dsc_pkg and the core.
`timescale 1ns / 100ps

module tb_image_downscale_2x2_box_average_core;

    localparam int          RESULT_LATENCY = 2;
    localparam int          SETTLE_CYCLES  = 2 * RESULT_LATENCY + 2;
    localparam int          RANDOM_PIXELS  = 180;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;

    typedef struct packed {
        logic        frame_end;
        logic [23:0] pixel;     // blue, green, red from the lowest bit up
    } scaled_pixel_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [dsc_pkg::CFG_IDX_W-1:0] cfg_index = dsc_pkg::REG_IMAGE_WIDTH;
    logic [dsc_pkg::DIM_W-1:0]     cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata = '0;  // blue_in, green_in, red_in
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [23:0]                   m_tdata;       // blue_out, green_out, red_out
    logic                          m_tlast;

    image_downscale_2x2_box_average_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Scaler state as the block should hold it
    logic [dsc_pkg::DIM_W-1:0] size_w = dsc_pkg::DIM_W'(640);
    logic [dsc_pkg::DIM_W-1:0] size_h = dsc_pkg::DIM_W'(480);
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [23:0]      held_px = '0;
    logic [26:0]      line_sums [0:dsc_pkg::LINE_DEPTH-1];

    logic [23:0]      pending_pixels [$];
    scaled_pixel_t    scaled_expected [$];
    int unsigned      pixels_queued = 0;
    int unsigned      pixels_in = 0;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      gap_left = 0;
    int unsigned      stall_left = 0;
    bit               src_idle = 1'b1;
    bit               sink_stall = 1'b1;
    string            chan_name [3] = '{"blue", "green", "red"};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input logic [dsc_pkg::DIM_W-1:0] v,
                                            input int unsigned lim);
        if (v == '0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        for (int c = 0; c < 3; c++)
        begin
            case ($urandom_range(0, 7))
                0:       p[c*8 +: 8] = 8'h00;
                1:       p[c*8 +: 8] = 8'hFF;
                default: p[c*8 +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    task automatic take_pixel(input logic [23:0] px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   we;
        int unsigned   he;
        logic [26:0]   pair;
        logic [26:0]   top;
        logic [9:0]    sum4;
        scaled_pixel_t res;
        w  = eff_dim(size_w, dsc_pkg::MAX_WIDTH);
        h  = eff_dim(size_h, dsc_pkg::MAX_HEIGHT);
        we = w - (w % 2);
        he = h - (h % 2);
        if (col_pos % 2 == 0)
            held_px = px;
        else if (col_pos < we && row_pos < he)
        begin
            for (int c = 0; c < 3; c++)
                pair[c*9 +: 9] = {1'b0, held_px[c*8 +: 8]} + {1'b0, px[c*8 +: 8]};
            if (row_pos % 2 == 0)
                line_sums[col_pos / 2] = pair;
            else
            begin
                top = line_sums[col_pos / 2];
                for (int c = 0; c < 3; c++)
                begin
                    sum4 = {1'b0, top[c*9 +: 9]} + {1'b0, pair[c*9 +: 9]};
                    res.pixel[c*8 +: 8] = sum4[9:2];
                end
                res.frame_end = (col_pos == we - 1) && (row_pos == he - 1);
                scaled_expected.push_back(res);
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Pixel source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pixels.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pixels.pop_front();
                gap_left <= src_idle ? $urandom_range(0, 15) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            take_pixel(s_tdata);
            pixels_in++;
        end
    end

    // Result sink and checker
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        scaled_pixel_t want;
        int unsigned   draw;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (scaled_expected.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual pixel %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = scaled_expected.pop_front();
                for (int c = 0; c < 3; c++)
                begin
                    if (m_tdata[c*8 +: 8] !== want.pixel[c*8 +: 8])
                    begin
                        $display("%0t: %s mismatch: expected %h, actual %h", $time,
                                 chan_name[c], want.pixel[c*8 +: 8], m_tdata[c*8 +: 8]);
                        error_count++;
                    end
                end
                if (m_tlast !== want.frame_end)
                begin
                    $display("%0t: frame_end mismatch: expected %b, actual %b",
                             $time, want.frame_end, m_tlast);
                    error_count++;
                end
            end
            draw = sink_stall ? $urandom_range(0, 15) : 0;
            stall_left <= draw;
            m_tready   <= (draw == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_image_downscale_2x2_box_average_core: errors");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [23:0] px);
        pending_pixels.push_back(px);
        pixels_queued++;
    endtask

    task automatic wait_drained();
        while (pixels_in != pixels_queued || scaled_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input dsc_pkg::cfg_reg_t r,
                              input logic [dsc_pkg::DIM_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (r == dsc_pkg::REG_IMAGE_WIDTH)
            size_w = v;
        else
            size_h = v;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic run_phase(input bit set_w, input logic [dsc_pkg::DIM_W-1:0] w,
                             input bit set_h, input logic [dsc_pkg::DIM_W-1:0] h,
                             input int unsigned count);
        if (set_w)
            write_size(dsc_pkg::REG_IMAGE_WIDTH, w);
        if (set_h)
            write_size(dsc_pkg::REG_IMAGE_HEIGHT, h);
        src_idle   = ($urandom_range(0, 3) != 0);
        sink_stall = ($urandom_range(0, 3) != 0);
        repeat (count) queue_pixel(rand_pixel());
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [dsc_pkg::DIM_W-1:0] w;
        logic [dsc_pkg::DIM_W-1:0] h;
        int unsigned      cap;
        int unsigned      random_items;
        int unsigned      mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on size: one full row and part of the next
        run_phase(1'b0, '0, 1'b0, '0, 680);

        // Directed: saturated blocks, minimum sums, frame end
        write_size(dsc_pkg::REG_IMAGE_WIDTH, dsc_pkg::DIM_W'(4));
        write_size(dsc_pkg::REG_IMAGE_HEIGHT, dsc_pkg::DIM_W'(2));
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'h010101);
        wait_drained();

        // Directed: odd last column and odd last row dropped
        write_size(dsc_pkg::REG_IMAGE_WIDTH, dsc_pkg::DIM_W'(3));
        write_size(dsc_pkg::REG_IMAGE_HEIGHT, dsc_pkg::DIM_W'(3));
        queue_pixel(24'h807F01);
        queue_pixel(24'h7F80FE);
        queue_pixel(24'hAAAAAA);
        queue_pixel(24'h0155AA);
        queue_pixel(24'hFE01FF);
        queue_pixel(24'h123456);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'h55AA55);
        wait_drained();

        // Oversized width, partial first row
        run_phase(1'b1, dsc_pkg::DIM_W'(8191), 1'b1, dsc_pkg::DIM_W'(2), 24);
        // Oversized height on a two-pixel-wide frame, first rows only
        run_phase(1'b1, dsc_pkg::DIM_W'(2), 1'b1, dsc_pkg::DIM_W'(4097), 24);
        // Exact maximum width, partial row
        run_phase(1'b1, dsc_pkg::DIM_W'(4096), 1'b1, dsc_pkg::DIM_W'(4096), 20);

        random_items = 0;
        while (random_items < RANDOM_PIXELS)
        begin
            w = dsc_pkg::DIM_W'($urandom_range(2, 12));
            h = dsc_pkg::DIM_W'($urandom_range(2, 12));
            case ($urandom_range(0, 7))
                0: w = dsc_pkg::DIM_W'($urandom_range(0, 1));
                1: h = dsc_pkg::DIM_W'($urandom_range(0, 1));
                2: w = dsc_pkg::DIM_W'($urandom_range(13, 64));
                default: ;
            endcase
            mode = $urandom_range(0, 5);
            if (mode != 1)
                write_size(dsc_pkg::REG_IMAGE_WIDTH, w);
            if (mode != 0)
                write_size(dsc_pkg::REG_IMAGE_HEIGHT, h);
            cap = 2 * eff_dim(size_w, dsc_pkg::MAX_WIDTH) * eff_dim(size_h, dsc_pkg::MAX_HEIGHT)
                  + eff_dim(size_w, dsc_pkg::MAX_WIDTH);
            if (cap > 150)
                cap = 150;
            cap = $urandom_range(1, cap);
            run_phase(1'b0, '0, 1'b0, '0, cap);
            random_items += cap;
        end

        wait_drained();
        if (error_count == 0)
            $display("tb_image_downscale_2x2_box_average_core: clean");
        else
            $display("tb_image_downscale_2x2_box_average_core: errors");
        $finish;
    end

endmodule
